>>> rtl/dda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line rasterizer package
// Shared constants and the sequencer state type of the line rasterizer.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COLOR_BITS     = 24;

  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y
  } dda_state_t;

endpackage

>>> rtl/dda_line_rasterizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line rasterizer
// Loads a line, divides both axis spans by the step count on one shared
// restoring divider, then emits one pixel per advance transfer.
// ----------------------------------------------------------------------------
// Start transfer: the input stalls while the shared divider produces the x
// and then the y increment; a zero-length line skips the divider.
// Advance transfer: one per cycle while the output is not stalled; the pixel
// appears in the output register on the cycle after the transfer.
// Reset (rst, synchronous, active high) drops any active line and clears
// round_mode.
module dda_line_rasterizer_unit
  import dda_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic                  mode,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  input  logic [COLOR_BITS-1:0] line_color,
  output logic                  pixel_valid,
  input  logic                  pixel_stall,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic [COLOR_BITS-1:0] pixel_color,
  output logic                  last_pixel,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data
);

  localparam int POS_W  = COORD_BITS + FRAC_BITS;
  localparam int STEP_W = FRAC_BITS + 2;
  localparam int REM_W  = COORD_BITS + 1;
  localparam int CNT_W  = $clog2(FRAC_BITS + 1);

  dda_state_t state, state_next;

  logic                  round_mode;
  logic [POS_W-1:0]      pos_x, pos_y;
  logic [STEP_W-1:0]     step_x, step_y;
  logic [COORD_BITS-1:0] steps_left;
  logic [COLOR_BITS-1:0] held_color;

  logic [COORD_BITS-1:0] count_r;
  logic [COORD_BITS-1:0] mag_y;
  logic                  neg_x, neg_y;
  logic [REM_W-1:0]      rem;
  logic [FRAC_BITS:0]    quot;
  logic [CNT_W-1:0]      cnt;

  logic                  item_fire;
  logic                  start_fire;
  logic                  adv_fire;
  logic                  dx_neg, dy_neg;
  logic [COORD_BITS-1:0] ax, ay, count;

  logic [REM_W:0]        div_diff;
  logic                  div_ge;
  logic [REM_W-1:0]      rem_sel;
  logic [FRAC_BITS:0]    quot_next;
  logic                  div_done;
  logic                  div_neg;
  logic [STEP_W-1:0]     step_mag;
  logic [STEP_W-1:0]     step_new;

  logic [POS_W-1:0]      round_add;
  logic [POS_W-1:0]      pix_x_full, pix_y_full;

  assign item_fire  = item_valid && !item_stall;
  assign start_fire = item_fire && (mode == MODE_START);
  assign adv_fire   = item_fire && (mode == MODE_ADVANCE) && (steps_left != '0);

  assign dx_neg = x_end < x_start;
  assign dy_neg = y_end < y_start;
  assign ax     = dx_neg ? (x_start - x_end) : (x_end - x_start);
  assign ay     = dy_neg ? (y_start - y_end) : (y_end - y_start);
  assign count  = (ax > ay) ? ax : ay;

  // One restoring division step: quotient bit FRAC_BITS first, since the
  // span never exceeds the step count.
  assign div_diff  = {1'b0, rem} - {2'b00, count_r};
  assign div_ge    = !div_diff[REM_W];
  assign rem_sel   = div_ge ? div_diff[REM_W-1:0] : rem;
  assign quot_next = {quot[FRAC_BITS-1:0], div_ge};
  assign div_done  = (cnt == CNT_W'(FRAC_BITS));
  assign div_neg   = (state == ST_DIV_X) ? neg_x : neg_y;
  assign step_mag  = {1'b0, quot_next};
  assign step_new  = div_neg ? (STEP_W'(0) - step_mag) : step_mag;

  assign round_add  = round_mode ? (POS_W'(1) << (FRAC_BITS - 1)) : '0;
  assign pix_x_full = pos_x + round_add;
  assign pix_y_full = pos_y + round_add;

  assign cfg_ready = 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start_fire && (count != '0)) begin
          state_next = ST_DIV_X;
        end
      end
      ST_DIV_X: begin
        if (div_done) begin
          state_next = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (div_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      ST_IDLE: item_stall = pixel_valid && pixel_stall;
      default: item_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      round_mode <= 1'b0;
      steps_left <= '0;
      pixel_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        round_mode <= cfg_data;
      end
      if (start_fire) begin
        steps_left <= count;
      end else if (adv_fire) begin
        steps_left <= steps_left - COORD_BITS'(1);
      end
      if (adv_fire) begin
        pixel_valid <= 1'b1;
      end else if (!pixel_stall) begin
        pixel_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_fire) begin
      pos_x      <= {x_start, FRAC_BITS'(0)};
      pos_y      <= {y_start, FRAC_BITS'(0)};
      held_color <= line_color;
      count_r    <= count;
      mag_y      <= ay;
      neg_x      <= dx_neg;
      neg_y      <= dy_neg;
      rem        <= {1'b0, ax};
      quot       <= '0;
      cnt        <= '0;
      if (count == '0) begin
        step_x <= '0;
        step_y <= '0;
      end
    end else if (adv_fire) begin
      pos_x <= pos_x + {{(POS_W-STEP_W){step_x[STEP_W-1]}}, step_x};
      pos_y <= pos_y + {{(POS_W-STEP_W){step_y[STEP_W-1]}}, step_y};
    end
    if (state == ST_DIV_X || state == ST_DIV_Y) begin
      if (div_done) begin
        cnt  <= '0;
        quot <= '0;
        rem  <= {1'b0, mag_y};
        if (state == ST_DIV_X) begin
          step_x <= step_new;
        end else begin
          step_y <= step_new;
        end
      end else begin
        cnt  <= cnt + CNT_W'(1);
        quot <= quot_next;
        rem  <= {rem_sel[REM_W-2:0], 1'b0};
      end
    end
    if (adv_fire) begin
      pixel_x     <= pix_x_full[POS_W-1:FRAC_BITS];
      pixel_y     <= pix_y_full[POS_W-1:FRAC_BITS];
      pixel_color <= held_color;
      last_pixel  <= (steps_left == COORD_BITS'(1));
    end
  end

endmodule

>>> rtl/dda_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line rasterizer checker
// Port-level checks of the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module dda_checker
  import dda_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  item_valid,
  input logic                  item_stall,
  input logic                  mode,
  input logic [COORD_BITS-1:0] x_start,
  input logic [COORD_BITS-1:0] y_start,
  input logic [COORD_BITS-1:0] x_end,
  input logic [COORD_BITS-1:0] y_end,
  input logic                  pixel_valid,
  input logic                  pixel_stall,
  input logic [COORD_BITS-1:0] pixel_x,
  input logic [COORD_BITS-1:0] pixel_y
);

  localparam int DIV_CYCLES = FRAC_BITS + 1;

  // A pending pixel holds while the consumer stalls.
  assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_x) && $stable(pixel_y))
    else $error("stalled pixel changed or dropped");

  // A new pixel only follows an accepted advance transfer.
  assert property (@(posedge clk) disable iff (rst)
    $rose(pixel_valid) |-> $past(item_valid && !item_stall && mode == MODE_ADVANCE))
    else $error("pixel without an advance transfer");

  // A line of nonzero length occupies the divider before the next transfer.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && mode == MODE_START &&
    (x_start != x_end || y_start != y_end) |=> item_stall ##DIV_CYCLES item_stall)
    else $error("input accepted during increment division");

  // A stalled output blocks the input.
  assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |-> item_stall)
    else $error("input accepted while the output register is full");

endmodule

bind dda_line_rasterizer_unit dda_checker #(
  .COORD_BITS(COORD_BITS),
  .FRAC_BITS (FRAC_BITS)
) u_dda_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item_valid),
  .item_stall (item_stall),
  .mode       (mode),
  .x_start    (x_start),
  .y_start    (y_start),
  .x_end      (x_end),
  .y_end      (y_end),
  .pixel_valid(pixel_valid),
  .pixel_stall(pixel_stall),
  .pixel_x    (pixel_x),
  .pixel_y    (pixel_y)
);
